// ----- rtl/qph_pkg.sv -----
// Shared types and constants for the quadratic-probe hash table.
package qph_pkg;

    localparam int TABLE_SLOTS = 1024;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int STEP_W      = SLOT_W + 1;
    localparam int KEY_W       = 54;
    localparam int DATA_W      = 32;
    localparam int PROD_W      = 64;
    localparam int MULT_W      = 10;
    localparam int WORD_W      = 1 + KEY_W + DATA_W;

    // floor(P/10^12) = floor((P >> 12) * RECIP / 2^80), RECIP = ceil(2^92/10^12),
    // exact for every P below 2^64
    localparam int DIV_SHIFT   = 12;
    localparam int NUM_W       = PROD_W - DIV_SHIFT;
    localparam int NUM_HALF    = NUM_W / 2;
    localparam int RECIP_W     = 53;
    localparam int RCP_LO_W    = 27;
    localparam int HOME_LSB    = 80;
    localparam int ACC_W       = HOME_LSB + SLOT_W;

    localparam logic [MULT_W-1:0]   HASH_MUL    = MULT_W'(739);
    localparam logic [RECIP_W-1:0]  HASH_RECIP  = 53'd4951760157141522;
    localparam logic [RCP_LO_W-1:0] RECIP_LO    = HASH_RECIP[RCP_LO_W-1:0];
    localparam logic [RCP_LO_W-1:0] RECIP_HI    = RCP_LO_W'(HASH_RECIP[RECIP_W-1:RCP_LO_W]);
    localparam logic [STEP_W-1:0]   PROBE_LIMIT = STEP_W'(TABLE_SLOTS - 1);

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_FOUND     = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_EXHAUSTED = 3'd5,
        ST_EMPTY     = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_MUL,
        FR_DIV,
        FR_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_PROBE
    } back_state_t;

    // Hashed request passed from front to back
    typedef struct packed {
        logic              action;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
        logic [SLOT_W-1:0] home;
    } req_t;

endpackage

// ----- rtl/qph_front.sv -----
// Front end: accepts requests and computes the home slot by reciprocal multiplication.
module qph_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        action,
    input  logic [qph_pkg::KEY_W-1:0]   key,
    input  logic [qph_pkg::DATA_W-1:0]  entry_data,
    input  logic                        clearing,
    input  logic                        q_full,
    output logic                        q_push,
    output qph_pkg::req_t               q_req
);

    localparam int PP_W = qph_pkg::NUM_HALF + qph_pkg::RCP_LO_W;

    qph_pkg::front_state_t state_reg, state_next;
    logic                        action_reg, action_next;
    logic [qph_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [qph_pkg::DATA_W-1:0]  data_reg, data_next;
    logic [qph_pkg::NUM_W-1:0]   num_reg, num_next;
    logic [qph_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic [1:0]                  part_reg, part_next;
    logic [qph_pkg::PROD_W-1:0]  product;
    logic [qph_pkg::NUM_HALF-1:0] mul_a;
    logic [qph_pkg::RCP_LO_W-1:0] mul_b;
    logic [PP_W-1:0]             partial;
    logic [qph_pkg::ACC_W-1:0]   partial_sh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qph_pkg::FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        key_reg    <= key_next;
        data_reg   <= data_next;
        num_reg    <= num_next;
        acc_reg    <= acc_next;
        part_reg   <= part_next;
    end

    assign product = qph_pkg::PROD_W'(key_reg) * qph_pkg::PROD_W'(qph_pkg::HASH_MUL);

    // one partial product a cycle: bit 1 picks the numerator half, bit 0 the reciprocal half
    assign mul_a   = part_reg[1] ? num_reg[qph_pkg::NUM_W-1:qph_pkg::NUM_HALF]
                                 : num_reg[qph_pkg::NUM_HALF-1:0];
    assign mul_b   = part_reg[0] ? qph_pkg::RECIP_HI : qph_pkg::RECIP_LO;
    assign partial = PP_W'(mul_a) * PP_W'(mul_b);

    always_comb
    begin
        case (part_reg)
            2'd0:    partial_sh = qph_pkg::ACC_W'(partial);
            2'd1:    partial_sh = qph_pkg::ACC_W'(partial) << qph_pkg::RCP_LO_W;
            2'd2:    partial_sh = qph_pkg::ACC_W'(partial) << qph_pkg::NUM_HALF;
            2'd3:    partial_sh = qph_pkg::ACC_W'(partial) << PP_W;
            default: partial_sh = '0;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        action_next = action_reg;
        key_next    = key_reg;
        data_next   = data_reg;
        num_next    = num_reg;
        acc_next    = acc_reg;
        part_next   = part_reg;
        in_stall    = 1'b1;
        q_push      = 1'b0;
        q_req.action = action_reg;
        q_req.key    = key_reg;
        q_req.data   = data_reg;
        q_req.home   = acc_reg[qph_pkg::ACC_W-1:qph_pkg::HOME_LSB];
        case (state_reg)
            qph_pkg::FR_IDLE:
            begin
                in_stall = clearing;
                if (in_valid && !clearing)
                begin
                    action_next = action;
                    key_next    = key;
                    data_next   = entry_data;
                    state_next  = qph_pkg::FR_MUL;
                end
            end
            qph_pkg::FR_MUL:
            begin
                // low 12 bits of the product cannot change the quotient
                num_next   = product[qph_pkg::PROD_W-1:qph_pkg::DIV_SHIFT];
                acc_next   = '0;
                part_next  = 2'd0;
                state_next = qph_pkg::FR_DIV;
            end
            qph_pkg::FR_DIV:
            begin
                // sum kept modulo 2^ACC_W; only the home bits at the top are used
                acc_next  = acc_reg + partial_sh;
                part_next = part_reg + 2'd1;
                if (part_reg == 2'd3)
                begin
                    state_next = qph_pkg::FR_PUSH;
                end
            end
            qph_pkg::FR_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = qph_pkg::FR_IDLE;
                end
            end
            default:
            begin
                state_next = qph_pkg::FR_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/qph_fifo.sv -----
// Two-entry request queue between front and back.
module qph_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  qph_pkg::req_t push_req,
    input  logic          pop,
    output qph_pkg::req_t head,
    output logic          not_empty,
    output logic          full
);

    qph_pkg::req_t entries_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_req;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    assign head      = entries_reg[rd_ptr_reg];
    assign not_empty = (cnt_reg != 2'd0);
    assign full      = (cnt_reg == 2'd2);

endmodule

// ----- rtl/qph_back.sv -----
// Back end: table memory, probe sequencer, clearing pass and result register.
module qph_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  qph_pkg::req_t                head,
    input  logic                         q_not_empty,
    output logic                         q_pop,
    output logic                         clearing,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [2:0]                   status,
    output logic [qph_pkg::SLOT_W-1:0]   slot,
    output logic [qph_pkg::DATA_W-1:0]   data_out
);

    localparam int SW = qph_pkg::SLOT_W;

    logic [qph_pkg::WORD_W-1:0] mem [qph_pkg::TABLE_SLOTS];
    logic [qph_pkg::WORD_W-1:0] rd_word;
    logic [SW-1:0]              rd_addr;
    logic                       we;
    logic [SW-1:0]              wa;
    logic [qph_pkg::WORD_W-1:0] wd;

    qph_pkg::back_state_t        state_reg, state_next;
    logic [SW-1:0]               clr_reg, clr_next;
    logic [qph_pkg::CNT_W-1:0]   count_reg, count_next;
    qph_pkg::req_t               item_reg, item_next;
    logic [SW-1:0]               pos_reg, pos_next;
    logic [qph_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        out_valid_reg, out_valid_next;
    qph_pkg::status_t            status_reg, status_next;
    logic [SW-1:0]               slot_reg, slot_next;
    logic [qph_pkg::DATA_W-1:0]  dout_reg, dout_next;

    logic                        out_free;
    logic                        e_valid;
    logic [qph_pkg::KEY_W-1:0]   e_key;
    logic [qph_pkg::DATA_W-1:0]  e_data;
    logic                        step_ok;
    logic                        hit;
    logic [SW-1:0]               half;
    logic [2*SW-1:0]             square;
    logic [SW-1:0]               offset;
    logic [SW-1:0]               npos;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_word <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qph_pkg::BK_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        pos_reg    <= pos_next;
        step_reg   <= step_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        dout_reg   <= dout_next;
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign e_valid  = rd_word[qph_pkg::WORD_W-1];
    assign e_key    = rd_word[qph_pkg::KEY_W+qph_pkg::DATA_W-1:qph_pkg::DATA_W];
    assign e_data   = rd_word[qph_pkg::DATA_W-1:0];
    assign step_ok  = (step_reg <= qph_pkg::PROBE_LIMIT);
    assign hit      = e_valid && step_ok && (e_key == item_reg.key);

    // offset for this step is (step/2)^2 mod slots; odd steps go downwards
    assign half   = step_reg[SW:1];
    assign square = (2*SW)'(half) * (2*SW)'(half);
    assign offset = square[SW-1:0];
    assign npos   = step_reg[0] ? (item_reg.home - offset) : (item_reg.home + offset);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        count_next     = count_reg;
        item_next      = item_reg;
        pos_next       = pos_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        slot_next      = slot_reg;
        dout_next      = dout_reg;
        q_pop          = 1'b0;
        we             = 1'b0;
        wa             = pos_reg;
        wd             = {1'b1, item_reg.key, item_reg.data};
        rd_addr        = pos_reg;
        clearing       = 1'b0;
        case (state_reg)
            qph_pkg::BK_CLEAR:
            begin
                clearing = 1'b1;
                we       = 1'b1;
                wa       = clr_reg;
                wd       = '0;
                clr_next = clr_reg + SW'(1);
                if (clr_reg == SW'(qph_pkg::TABLE_SLOTS - 1))
                begin
                    state_next = qph_pkg::BK_IDLE;
                end
            end
            qph_pkg::BK_IDLE:
            begin
                rd_addr = head.home;
                if (q_not_empty)
                begin
                    if (head.action == qph_pkg::ACT_INSERT && count_reg[qph_pkg::CNT_W-1])
                    begin
                        if (out_free)
                        begin
                            q_pop          = 1'b1;
                            out_valid_next = 1'b1;
                            status_next    = qph_pkg::ST_FULL;
                            slot_next      = '0;
                            dout_next      = '0;
                        end
                    end
                    else if (head.action == qph_pkg::ACT_LOOKUP && count_reg == '0)
                    begin
                        if (out_free)
                        begin
                            q_pop          = 1'b1;
                            out_valid_next = 1'b1;
                            status_next    = qph_pkg::ST_EMPTY;
                            slot_next      = '0;
                            dout_next      = '0;
                        end
                    end
                    else
                    begin
                        q_pop      = 1'b1;
                        item_next  = head;
                        pos_next   = head.home;
                        step_next  = qph_pkg::STEP_W'(1);
                        state_next = qph_pkg::BK_PROBE;
                    end
                end
            end
            qph_pkg::BK_PROBE:
            begin
                if (e_valid && step_ok && !hit)
                begin
                    pos_next  = npos;
                    step_next = step_reg + qph_pkg::STEP_W'(1);
                    rd_addr   = npos;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    slot_next      = '0;
                    dout_next      = '0;
                    state_next     = qph_pkg::BK_IDLE;
                    if (hit)
                    begin
                        slot_next = pos_reg;
                        if (item_reg.action == qph_pkg::ACT_LOOKUP)
                        begin
                            status_next = qph_pkg::ST_FOUND;
                            dout_next   = e_data;
                        end
                        else
                        begin
                            status_next = qph_pkg::ST_DUPLICATE;
                        end
                    end
                    else if (item_reg.action == qph_pkg::ACT_LOOKUP)
                    begin
                        status_next = qph_pkg::ST_NOT_FOUND;
                    end
                    else if (!step_ok)
                    begin
                        status_next = qph_pkg::ST_EXHAUSTED;
                    end
                    else
                    begin
                        we          = 1'b1;
                        count_next  = count_reg + qph_pkg::CNT_W'(1);
                        status_next = qph_pkg::ST_INSERTED;
                        slot_next   = pos_reg;
                    end
                end
            end
            default:
            begin
                state_next = qph_pkg::BK_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign slot      = slot_reg;
    assign data_out  = dout_reg;

endmodule

// ----- rtl/quadratic_probe_hash_table.sv -----
// Top level of the open-addressing hash table with alternating quadratic probing.
// Keyed table of 1024 slots. A word on the input channel is an insert (action 0,
// key and entry_data) or a lookup (action 1, key); each gives exactly one result
// word (status, slot, data_out) in request order. The front end multiplies the key
// by 739 and divides by 10^12 through a reciprocal multiply done as four partial
// products, one a cycle, after its accept and multiply steps and before its push
// step, and a two-word queue lets the next word hash while the back end probes.
// The back end takes one request at a time from the queue and reads the table
// memory once per probe; the slower of the two ends sets the sustained rate,
// typically the hash at moderate load. After reset the back end clears the table
// memory, one slot a cycle; input stays stalled until that pass ends. The output
// word is held in a register, so the front end and queue keep working while a
// result waits on out_stall.
module quadratic_probe_hash_table (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 action,
    input  logic [qph_pkg::KEY_W-1:0]            key,
    input  logic [qph_pkg::DATA_W-1:0]           entry_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [2:0]                           status,
    output logic [qph_pkg::SLOT_W-1:0]           slot,
    output logic [qph_pkg::DATA_W-1:0]           data_out
);

    qph_pkg::req_t push_req;
    qph_pkg::req_t head;
    logic          push;
    logic          pop;
    logic          not_empty;
    logic          full;
    logic          clearing;

    // hashing front end
    qph_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .key        (key),
        .entry_data (entry_data),
        .clearing   (clearing),
        .q_full     (full),
        .q_push     (push),
        .q_req      (push_req)
    );

    // decoupling queue
    qph_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_req  (push_req),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .full      (full)
    );

    // probing back end with table memory
    qph_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_not_empty (not_empty),
        .q_pop       (pop),
        .clearing    (clearing),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .slot        (slot),
        .data_out    (data_out)
    );

endmodule

// ----- test/quadratic_probe_hash_table_test.sv -----
// Regression bench for the quadratic-probe hash table: directed and random words, with a predicted result for each.
module quadratic_probe_hash_table_test;
    import qph_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] data;
    } reply_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                action;
    logic [KEY_W-1:0]    key;
    logic [DATA_W-1:0]   entry_data;
    logic                out_valid;
    logic                out_stall;
    logic [2:0]          status;
    logic [SLOT_W-1:0]   slot;
    logic [DATA_W-1:0]   data_out;

    quadratic_probe_hash_table uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .key        (key),
        .entry_data (entry_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .slot       (slot),
        .data_out   (data_out)
    );

    // Shadow table, kept in step with every accepted word
    logic [KEY_W-1:0]  shadow_keys [TABLE_SLOTS];
    logic [DATA_W-1:0] shadow_data [TABLE_SLOTS];
    logic              shadow_used [TABLE_SLOTS];
    int unsigned       shadow_count;

    reply_t      pending_replies[$];
    reply_t      last_reply;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned quiet_cycles;
    bit          failed;

    // Keys sent with inserts, reused so that lookups and duplicates can hit
    logic [KEY_W-1:0] known_keys[$];

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [SLOT_W-1:0] home_of(logic [KEY_W-1:0] k);
        logic [127:0] prod;
        prod = 128'(k) * 128'd739;
        return SLOT_W'(prod / 128'd1000000000000);
    endfunction

    // Work out the reply to one word and update the shadow table
    function automatic reply_t predict_reply(logic act, logic [KEY_W-1:0] k,
                                             logic [DATA_W-1:0] d);
        reply_t            r;
        logic [SLOT_W-1:0] home;
        logic [SLOT_W-1:0] pos;
        logic [SLOT_W-1:0] off;
        int unsigned       step;
        int unsigned       half;
        r = '0;
        if (act == ACT_INSERT && shadow_count >= TABLE_SLOTS)
        begin
            r.status = ST_FULL;
            return r;
        end
        if (act == ACT_LOOKUP && shadow_count == 0)
        begin
            r.status = ST_EMPTY;
            return r;
        end
        home = home_of(k);
        pos  = home;
        step = 1;
        while (shadow_used[pos] && step <= TABLE_SLOTS - 1)
        begin
            if (shadow_keys[pos] == k)
            begin
                r.slot = pos;
                if (act == ACT_LOOKUP)
                begin
                    r.status = ST_FOUND;
                    r.data   = shadow_data[pos];
                end
                else
                    r.status = ST_DUPLICATE;
                return r;
            end
            half = step / 2;
            off  = SLOT_W'(half * half);
            pos  = (step % 2 == 0) ? home + off : home - off;
            step++;
        end
        if (act == ACT_LOOKUP)
            r.status = ST_NOT_FOUND;
        else if (step > TABLE_SLOTS - 1)
            r.status = ST_EXHAUSTED;
        else
        begin
            shadow_used[pos] = 1'b1;
            shadow_keys[pos] = k;
            shadow_data[pos] = d;
            shadow_count++;
            r.status = ST_INSERTED;
            r.slot   = pos;
        end
        return r;
    endfunction

    // Send one word; prediction is made when it is accepted. in_valid is dropped
    // by the next idle cycle or by wait_drained.
    task automatic send_word(logic act, logic [KEY_W-1:0] k, logic [DATA_W-1:0] d);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        key        <= k;
        entry_data <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        last_reply = predict_reply(act, k, d);
        pending_replies.push_back(last_reply);
        if (act == ACT_INSERT)
            known_keys.push_back(k);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    // Key that hashes to a chosen home slot: key = ceil((h + wraps*1024)*10^12/739)
    function automatic logic [KEY_W-1:0] key_for_home(int unsigned h, int unsigned wraps);
        logic [127:0] target;
        target = 128'(h + wraps * TABLE_SLOTS);
        return KEY_W'((target * 128'd1000000000000 + 128'd738) / 128'd739);
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        return KEY_W'({$urandom, $urandom});
    endfunction

    // Receiver stalls and result checks
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_replies.size() == 0)
                begin
                    $error("result with none expected: status %0d", status);
                    failed = 1'b1;
                end
                else
                begin
                    reply_t want;
                    want = pending_replies.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        failed = 1'b1;
                    end
                    if (slot !== want.slot)
                    begin
                        $error("slot: expected %0d, got %0d", want.slot, slot);
                        failed = 1'b1;
                    end
                    if (data_out !== want.data)
                    begin
                        $error("data_out: expected %h, got %h", want.data, data_out);
                        failed = 1'b1;
                    end
                end
            end
            out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog on cycles with no word moving; reset clearing pass included
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("quadratic_probe_hash_table regression: fail");
            $finish;
        end
    end

    // Empty table, extremes of key and data inserted and found, a miss, a duplicate, then collisions
    task automatic test_directed();
        send_word(ACT_LOOKUP, '0, '0);
        send_word(ACT_INSERT, '0, 32'hFFFF_FFFF);
        send_word(ACT_INSERT, {KEY_W{1'b1}}, 32'h0000_0000);
        send_word(ACT_INSERT, 54'h2AAAAAAAAAAAAA, 32'h5555_5555);
        send_word(ACT_INSERT, 54'h15555555555555, 32'hAAAA_AAAA);
        send_word(ACT_LOOKUP, '0, 32'hFFFF_FFFF);
        send_word(ACT_LOOKUP, {KEY_W{1'b1}}, '0);
        send_word(ACT_LOOKUP, 54'h2AAAAAAAAAAAAA, '0);
        send_word(ACT_LOOKUP, 54'h15555555555555, '0);
        send_word(ACT_LOOKUP, 54'd12345, '0);
        // duplicate insert
        send_word(ACT_INSERT, '0, 32'h1234_5678);
        // collisions on one home slot: walk the alternating probe order
        for (int i = 0; i < 6; i++)
            send_word(ACT_INSERT, key_for_home(5, i), $urandom);
        for (int i = 0; i < 7; i++)
            send_word(ACT_LOOKUP, key_for_home(5, i), '0);
    endtask

    // Random mix of lookups and inserts: half on known keys, the rest random or with clustered homes
    task automatic test_random(int unsigned n, int unsigned idle_pct, int unsigned stall_pct);
        logic [KEY_W-1:0] k;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int unsigned i = 0; i < n; i++)
        begin
            case ($urandom_range(3))
                0: k = random_key();
                1: k = key_for_home($urandom_range(15), $urandom_range(8000));
                default: k = known_keys.size() ? known_keys[$urandom_range(known_keys.size()-1)]
                                               : random_key();
            endcase
            send_word($urandom_range(1) ? ACT_LOOKUP : ACT_INSERT, k, $urandom);
        end
        wait_drained();
    endtask

    // Pile keys on one home until its walk runs out, then an insert, full-length misses and known-key lookups
    task automatic test_exhaust();
        int unsigned wraps;
        send_idle_pct  = 0;
        recv_stall_pct = 10;
        wraps          = 0;
        do
        begin
            send_word(ACT_INSERT, key_for_home(7, 9000 + wraps), $urandom);
            wraps++;
        end
        while (last_reply.status != ST_EXHAUSTED && wraps < 400);
        send_word(ACT_INSERT, key_for_home(7, 9600), $urandom);
        send_word(ACT_LOOKUP, key_for_home(7, 9700), '0);
        send_word(ACT_LOOKUP, key_for_home(7, 9701), '0);
        for (int i = 0; i < 10; i++)
            send_word(ACT_LOOKUP, known_keys[$urandom_range(known_keys.size()-1)], '0);
        wait_drained();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        action         = ACT_INSERT;
        key            = '0;
        entry_data     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;
        failed         = 1'b0;
        shadow_count   = 0;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            shadow_used[i] = 1'b0;
            shadow_keys[i] = '0;
            shadow_data[i] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random(80, 0, 0);
        // sender holds off until the table has answered everything
        wait_drained();
        test_random(80, 54, 0);
        test_random(80, 0, 54);
        test_random(80, 34, 34);
        test_random(80, 0, 0);
        test_exhaust();

        repeat (100) @(posedge clk);
        if (failed || pending_replies.size() != 0)
            $display("quadratic_probe_hash_table regression: fail");
        else
            $display("quadratic_probe_hash_table regression: pass");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/qph_pkg.sv
rtl/qph_front.sv
rtl/qph_fifo.sv
rtl/qph_back.sv
rtl/quadratic_probe_hash_table.sv
test/quadratic_probe_hash_table_test.sv
